>>> design/ptd_pkg.sv
package ptd_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam logic [1:0] FMT_DIRECT = 2'd0;
    localparam logic [1:0] FMT_INDEX8 = 2'd1;
    localparam logic [1:0] FMT_INDEX4 = 2'd2;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_TEXEL     = 1'b1;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic        command;
        logic [7:0]  palette_slot;
        logic [31:0] palette_color;
        logic [31:0] texel_word;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] argb_pixel;
        logic        palette_missing;
    } t_out_beat;

    typedef enum logic [1:0] {
        SRC_DIRECT,
        SRC_PALETTE,
        SRC_MISSING,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        t_src        src;
        logic [31:0] texel;
    } t_s1_ctrl;

    function automatic logic [31:0] rgba_to_argb(input logic [31:0] c);
        rgba_to_argb = {c[31:24], c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

>>> design/ptd_palette_ram.sv
module ptd_palette_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ptd_pkg::PAL_AW-1:0] i_wr_addr,
    input  logic [31:0]               i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ptd_pkg::PAL_AW-1:0] i_rd_addr,
    output logic [31:0]               o_rd_data
);
    import ptd_pkg::*;

    logic [31:0] r_mem [PALETTE_ENTRIES];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ptd_pixel_stage.sv
module ptd_pixel_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ptd_pkg::t_s1_ctrl i_ctrl,
    input  logic [31:0]       i_rd_data,
    input  logic              i_out_stall,
    output logic              o_hold,
    output logic              o_out_valid,
    output ptd_pkg::t_out_beat o_out_beat
);
    import ptd_pkg::*;

    logic      r_s1_valid;
    t_s1_ctrl  r_s1_ctrl;
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      n_s1_valid;
    logic      n_out_valid;
    t_out_beat n_out_beat;
    logic      out_free;
    logic      s1_move;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_hold   = r_s1_valid && !out_free;

    always_comb begin
        n_out_beat = '0;
        case (r_s1_ctrl.src)
            SRC_DIRECT:  n_out_beat.argb_pixel = rgba_to_argb(r_s1_ctrl.texel);
            SRC_PALETTE: n_out_beat.argb_pixel = rgba_to_argb(i_rd_data);
            SRC_MISSING: n_out_beat.palette_missing = 1'b1;
            default:     n_out_beat = '0;
        endcase
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_ctrl <= i_ctrl;
        end
        if (s1_move) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

>>> design/palette_texel_decoder.sv
// palette texel decoder: one texel beat in, one ARGB8888 beat out
// input channel i_in_valid / o_in_stall carries either a palette write
// (command 0: slot and RGBA color) or a texel (command 1)
// palette writes go straight into the palette RAM and give no output beat
// texel beats give one output beat on o_out_valid / i_out_stall
// config channel i_cfg_valid / o_cfg_ready writes pixel_format; ready is
// always high, write it only while no texel is in flight
// an accepted texel waits in the read stage, then moves to the output register once it is free
// throughput: one beat per cycle while the output is not stalled, set by the
// single palette RAM port pair (one write per palette beat, one registered
// read per palette texel); a palette write followed directly by a texel of
// the same slot reads the new color since the RAM write lands before the read
// when the receiver stalls the output holds; one more texel fits in the
// read stage, after that o_in_stall rises until the output drains
// reset (synchronous, active low) empties the pipe, sets direct format and
// clears the palette-loaded flag; the palette RAM itself is not cleared
module palette_texel_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptd_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptd_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);
    import ptd_pkg::*;

    logic [1:0]  r_fmt;
    logic        r_loaded;
    logic        accept;
    logic        pal_wr;
    logic        texel_acc;
    logic        slot_ok;
    logic [7:0]  idx;
    logic        idx_ok;
    t_s1_ctrl    ctrl;
    logic        rd_en;
    logic [31:0] rd_data;
    logic        hold;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = hold;
    assign accept      = i_in_valid && !hold;

    assign slot_ok   = {1'b0, i_in_beat.palette_slot} < 9'(PALETTE_ENTRIES);
    assign pal_wr    = accept && (i_in_beat.command == CMD_PAL_WRITE) && slot_ok;
    assign texel_acc = accept && (i_in_beat.command == CMD_TEXEL);

    assign idx    = (r_fmt == FMT_INDEX4) ? (i_in_beat.texel_word[7:0] & NIBBLE_MASK)
                                          : i_in_beat.texel_word[7:0];
    assign idx_ok = {1'b0, idx} < 9'(PALETTE_ENTRIES);

    always_comb begin
        ctrl.texel = i_in_beat.texel_word;
        unique case (r_fmt) inside
            FMT_DIRECT: ctrl.src = SRC_DIRECT;
            FMT_INDEX8, FMT_INDEX4: begin
                if (!r_loaded) begin
                    ctrl.src = SRC_MISSING;
                end else if (idx_ok) begin
                    ctrl.src = SRC_PALETTE;
                end else begin
                    ctrl.src = SRC_ZERO;
                end
            end
            default: ctrl.src = SRC_MISSING;
        endcase
    end

    assign rd_en = texel_acc && (ctrl.src == SRC_PALETTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_DIRECT;
            r_loaded <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            if (pal_wr) begin
                r_loaded <= 1'b1;
            end
        end
    end

    ptd_palette_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pal_wr),
        .i_wr_addr (i_in_beat.palette_slot[PAL_AW-1:0]),
        .i_wr_data (i_in_beat.palette_color),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx[PAL_AW-1:0]),
        .o_rd_data (rd_data)
    );

    ptd_pixel_stage u_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (texel_acc),
        .i_ctrl      (ctrl),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

>>> design/ptd_checker.sv
module ptd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ptd_pkg::t_out_beat o_out_beat
);
    import ptd_pkg::*;

    // output beat stays while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // missing palette always comes with a zero pixel
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.palette_missing) |-> (o_out_beat.argb_pixel == 32'd0))
        else $error("missing palette with nonzero pixel");

    // input backs up only when the output is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind palette_texel_decoder ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
